// File: hw/rtl/cgrt_pkg.sv
// Package for the chunk gap report tracker: field widths, payload structs,
// result kinds, controller states and the controller-to-datapath command set.
// No dependencies.
package cgrt_pkg;

  localparam int IdW    = 16;
  localparam int ChunkW = 16;
  localparam int CntW   = 7;

  typedef enum logic [1:0] {
    KIND_STALE    = 2'd0,
    KIND_MISSING  = 2'd1,
    KIND_COMPLETE = 2'd2,
    KIND_FINISHED = 2'd3
  } kind_e;

  typedef struct packed {
    logic              func;
    logic [IdW-1:0]    packet_id;
    logic [ChunkW-1:0] request_chunk;
    logic [CntW-1:0]   packets_sent;
  } in_t;

  typedef struct packed {
    kind_e             kind;
    logic [ChunkW-1:0] reply_chunk;
    logic [CntW-1:0]   missing_id;
    logic [CntW-1:0]   missing_total;
    logic              last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MARK,
    OP_STALE,
    OP_FIN_AGAIN,
    OP_FIN_NOW,
    OP_LOAD,
    OP_COUNT,
    OP_COMPLETE,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic is_check;
    logic stale;
    logic done;
    logic sent_zero;
    logic at_end;
    logic bit_missing;
    logic total_zero;
    logic last_hit;
  } status_t;

endpackage

// File: hw/rtl/cgrt_ctrl.sv
// Controller state machine of the chunk gap report tracker.
// Depends on cgrt_pkg for states, commands and status.
module cgrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  cgrt_pkg::status_t status_i,
  output cgrt_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  cgrt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cgrt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = cgrt_pkg::OP_NONE;
    unique case (state_q)
      cgrt_pkg::ST_IDLE: begin
        if (start_i) begin
          if (!status_i.is_check) begin
            cmd_o.op = cgrt_pkg::OP_MARK;
          end else if (status_i.stale) begin
            cmd_o.op = cgrt_pkg::OP_STALE;
          end else if (status_i.done) begin
            cmd_o.op = cgrt_pkg::OP_FIN_AGAIN;
          end else if (status_i.sent_zero) begin
            cmd_o.op = cgrt_pkg::OP_FIN_NOW;
          end else begin
            cmd_o.op = cgrt_pkg::OP_LOAD;
            state_d  = cgrt_pkg::ST_COUNT;
          end
        end
      end
      cgrt_pkg::ST_COUNT: begin
        if (status_i.at_end && status_i.total_zero) begin
          cmd_o.op = cgrt_pkg::OP_COMPLETE;
          state_d  = cgrt_pkg::ST_IDLE;
        end else begin
          cmd_o.op = cgrt_pkg::OP_COUNT;
          if (status_i.at_end) begin
            state_d = cgrt_pkg::ST_EMIT;
          end
        end
      end
      cgrt_pkg::ST_EMIT: begin
        cmd_o.op = cgrt_pkg::OP_EMIT;
        if (status_i.bit_missing && status_i.last_hit) begin
          state_d = cgrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cgrt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != cgrt_pkg::ST_IDLE);

  // The walk only leaves the emit state on the last missing id.
  a_emit_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cgrt_pkg::ST_EMIT && state_d == cgrt_pkg::ST_IDLE) |->
      status_i.last_hit)
    else $error("emit state left before the last missing id");

endmodule

// File: hw/rtl/cgrt_datapath.sv
// Datapath of the chunk gap report tracker: received bitmap, chunk and done
// state, the walk counters and the result register. Depends on cgrt_pkg.
module cgrt_datapath #(
  parameter int MAX_PACKETS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cgrt_pkg::in_t     in_i,
  input  cgrt_pkg::cmd_t    cmd_i,
  output cgrt_pkg::status_t status_o,
  output cgrt_pkg::res_t    res_o,
  output logic              res_strobe_o
);

  localparam int IW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam logic [cgrt_pkg::CntW-1:0] MaxCnt = cgrt_pkg::CntW'(MAX_PACKETS);

  logic [MAX_PACKETS-1:0]          map_q, map_d;
  logic [cgrt_pkg::ChunkW-1:0]     chunk_q, chunk_d;
  logic                            done_q, done_d;
  logic [cgrt_pkg::CntW-1:0]       n_q, n_d;
  logic [cgrt_pkg::CntW-1:0]       idx_q, idx_d;
  logic [cgrt_pkg::CntW-1:0]       total_q, total_d;
  logic [cgrt_pkg::CntW-1:0]       k_q, k_d;
  cgrt_pkg::res_t                  res_q, res_d;
  logic                            strobe_q, strobe_d;

  logic                            pid_ok;
  logic [IW-1:0]                   mark_idx;
  logic [cgrt_pkg::CntW-1:0]       walk_m1;
  logic                            bit_missing;
  logic [cgrt_pkg::CntW-1:0]       sent_sat;

  assign pid_ok   = (in_i.packet_id != '0) &&
                    (in_i.packet_id <= cgrt_pkg::IdW'(MAX_PACKETS));
  assign mark_idx = IW'(in_i.packet_id - 16'd1);
  assign walk_m1  = idx_q - 7'd1;
  assign bit_missing = (walk_m1 < MaxCnt) && !map_q[IW'(walk_m1)];
  assign sent_sat = (in_i.packets_sent > MaxCnt) ? MaxCnt : in_i.packets_sent;

  assign status_o.is_check    = in_i.func;
  assign status_o.stale       = (in_i.request_chunk < chunk_q);
  assign status_o.done        = done_q;
  assign status_o.sent_zero   = (in_i.packets_sent == '0);
  assign status_o.at_end      = (idx_q == n_q);
  assign status_o.bit_missing = bit_missing;
  assign status_o.total_zero  = (total_q == '0) && !bit_missing;
  assign status_o.last_hit    = ((k_q + 7'd1) == total_q);

  always_comb begin
    map_d    = map_q;
    chunk_d  = chunk_q;
    done_d   = done_q;
    n_d      = n_q;
    idx_d    = idx_q;
    total_d  = total_q;
    k_d      = k_q;
    res_d    = res_q;
    strobe_d = 1'b0;
    unique case (cmd_i.op)
      cgrt_pkg::OP_MARK: begin
        if (pid_ok && !done_q) begin
          map_d[mark_idx] = 1'b1;
        end
      end
      cgrt_pkg::OP_STALE: begin
        strobe_d = 1'b1;
        res_d    = '{cgrt_pkg::KIND_STALE, in_i.request_chunk, '0, '0, 1'b1};
      end
      cgrt_pkg::OP_FIN_AGAIN: begin
        strobe_d = 1'b1;
        res_d    = '{cgrt_pkg::KIND_FINISHED, chunk_q, '0, '0, 1'b1};
      end
      cgrt_pkg::OP_FIN_NOW: begin
        strobe_d = 1'b1;
        res_d    = '{cgrt_pkg::KIND_FINISHED, chunk_q, '0, '0, 1'b1};
        map_d    = '0;
        chunk_d  = chunk_q + 16'd1;
        done_d   = 1'b1;
      end
      cgrt_pkg::OP_LOAD: begin
        n_d     = sent_sat;
        idx_d   = 7'd1;
        total_d = '0;
        k_d     = '0;
      end
      cgrt_pkg::OP_COUNT: begin
        total_d = total_q + cgrt_pkg::CntW'(bit_missing);
        idx_d   = (idx_q == n_q) ? 7'd1 : idx_q + 7'd1;
      end
      cgrt_pkg::OP_COMPLETE: begin
        strobe_d = 1'b1;
        res_d    = '{cgrt_pkg::KIND_COMPLETE, chunk_q, '0, '0, 1'b1};
        map_d    = '0;
        chunk_d  = chunk_q + 16'd1;
      end
      cgrt_pkg::OP_EMIT: begin
        if (bit_missing) begin
          strobe_d = 1'b1;
          res_d    = '{cgrt_pkg::KIND_MISSING, chunk_q, idx_q, total_q,
                       status_o.last_hit};
          k_d      = k_q + 7'd1;
        end
        idx_d = idx_q + 7'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q    <= '0;
      chunk_q  <= 16'd1;
      done_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      map_q    <= map_d;
      chunk_q  <= chunk_d;
      done_q   <= done_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    idx_q   <= idx_d;
    total_q <= total_d;
    k_q     <= k_d;
    res_q   <= res_d;
  end

  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

  // A missing id report names an id inside the walked range.
  a_missing_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && res_q.kind == cgrt_pkg::KIND_MISSING) |->
      (res_q.missing_id != '0 && res_q.missing_id <= MaxCnt))
    else $error("missing id report outside the bitmap");

  // Every reply other than a missing id report ends its run.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && res_q.kind != cgrt_pkg::KIND_MISSING) |-> res_q.last)
    else $error("single reply without last");

  // The emit pass never reports more ids than the count pass found.
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == cgrt_pkg::OP_EMIT && bit_missing) |-> (k_q < total_q))
    else $error("more missing ids emitted than counted");

endmodule

// File: hw/rtl/chunk_gap_report_tracker_unit.sv
// A payload transfer updates the bitmap register; a stale or finished reply appears in the
// cycle after its transfer. A chunk check first counts the missing ids over the saturated
// packet count, then walks the bitmap again to report them, one result per missing id.
// Throughput: one payload transfer per cycle unless busy_o is high, as in a check walk.
// Reset (rst_ni, async, active low) clears the bitmap and done flag, sets the chunk to one.
// Results are strobed for one cycle each; the receiver cannot stall them.
module chunk_gap_report_tracker_unit #(
  parameter int MAX_PACKETS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  cgrt_pkg::in_t  in_i,
  output cgrt_pkg::res_t res_o,
  output logic           res_strobe_o
);

  // The controller decides which datapath operation runs in each cycle. A transfer is
  // accepted when start_i is high and busy_o is low; only a check request that needs a
  // bitmap walk raises busy_o.
  cgrt_pkg::cmd_t    cmd;
  cgrt_pkg::status_t status;

  cgrt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // The datapath holds the received bitmap, the current chunk, the done flag, the walk
  // counters and the registered result that drives the output ports.
  cgrt_datapath #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench for chunk_gap_report_tracker_unit. It drives payload and check transfers,
// predicts every reply from its own model of the tracker, and compares the replies field by field.
// Depends on cgrt_pkg and the tracker RTL only.
module tb;

  localparam int MaxPackets  = 64;
  localparam bit FuncPayload = 1'b0;
  localparam bit FuncCheck   = 1'b1;
  // The idle limit leaves a wide margin over a full bitmap walk and a long sender gap.
  localparam int IdleLimit   = 2000;
  localparam int TailCycles  = 16;
  localparam int RandomItems = 180;
  localparam int ReportMax   = 10;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  cgrt_pkg::in_t  item;
  cgrt_pkg::res_t reply;
  logic           reply_strobe;

  // Tracker model: bitmap of received ids, current chunk and the finished flag.
  bit [MaxPackets-1:0]       rx_map;
  bit [cgrt_pkg::ChunkW-1:0] cur_chunk;
  bit                        xfer_done;

  // Replies the tracker still owes, oldest first.
  cgrt_pkg::res_t expected_replies[$];

  int mismatch_count;
  int items_sent;
  int idle_cycles;
  bit gaps_off;

  chunk_gap_report_tracker_unit #(
    .MAX_PACKETS(MaxPackets)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .in_i        (item),
    .res_o       (reply),
    .res_strobe_o(reply_strobe)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic cgrt_pkg::res_t make_reply(cgrt_pkg::kind_e kind,
                                                logic [cgrt_pkg::ChunkW-1:0] chunk,
                                                int unsigned id, int unsigned total, bit last);
    cgrt_pkg::res_t r;
    r.kind          = kind;
    r.reply_chunk   = chunk;
    r.missing_id    = cgrt_pkg::CntW'(id);
    r.missing_total = cgrt_pkg::CntW'(total);
    r.last          = last;
    return r;
  endfunction

  // Appends one reply to the tail of the list of owed replies.
  function automatic void owe_reply(cgrt_pkg::res_t r);
    expected_replies = {expected_replies, r};
  endfunction

  // Works out the replies that one accepted transfer causes and updates the model state.
  // The stale test comes first. Then a finished transfer answers every check the same way.
  // A check on a future chunk is treated as a check on the current chunk.
  function automatic void predict_replies(cgrt_pkg::in_t it);
    int unsigned span;
    int unsigned total;
    int unsigned seen;
    if (it.func == FuncPayload) begin
      if (!xfer_done && it.packet_id != 0 && it.packet_id <= MaxPackets)
        rx_map[it.packet_id - 1] = 1'b1;
    end else if (it.request_chunk < cur_chunk) begin
      owe_reply(make_reply(cgrt_pkg::KIND_STALE, it.request_chunk, 0, 0, 1'b1));
    end else if (xfer_done) begin
      owe_reply(make_reply(cgrt_pkg::KIND_FINISHED, cur_chunk, 0, 0, 1'b1));
    end else if (it.packets_sent == 0) begin
      owe_reply(make_reply(cgrt_pkg::KIND_FINISHED, cur_chunk, 0, 0, 1'b1));
      rx_map    = '0;
      cur_chunk = cur_chunk + 1'b1;
      xfer_done = 1'b1;
    end else begin
      // Counts above the bitmap size saturate.
      span  = (it.packets_sent > MaxPackets) ? MaxPackets : it.packets_sent;
      total = 0;
      for (int unsigned i = 1; i <= span; i++)
        if (!rx_map[i-1]) total++;
      if (total == 0) begin
        owe_reply(make_reply(cgrt_pkg::KIND_COMPLETE, cur_chunk, 0, 0, 1'b1));
        rx_map    = '0;
        cur_chunk = cur_chunk + 1'b1;
      end else begin
        seen = 0;
        for (int unsigned i = 1; i <= span; i++) begin
          if (!rx_map[i-1]) begin
            seen++;
            owe_reply(make_reply(cgrt_pkg::KIND_MISSING, cur_chunk, i, total, seen == total));
          end
        end
      end
    end
  endfunction

  function automatic void report_mismatch(string why, cgrt_pkg::res_t want,
                                          cgrt_pkg::res_t got);
    mismatch_count++;
    if (mismatch_count <= ReportMax) begin
      $display("[%0t] %s", $time, why);
      $display("  expected kind=%0d chunk=%0d id=%0d total=%0d last=%0d",
               want.kind, want.reply_chunk, want.missing_id, want.missing_total, want.last);
      $display("  actual   kind=%0d chunk=%0d id=%0d total=%0d last=%0d",
               got.kind, got.reply_chunk, got.missing_id, got.missing_total, got.last);
    end
  endfunction

  // Most gaps are short. A few are much longer.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (gaps_off || roll < 55) return 0;
    else if (roll < 92) return $urandom_range(1, 3);
    else return $urandom_range(6, 40);
  endfunction

  task automatic hold_off(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Presents one transfer and waits until the tracker takes it. Start stays high on return,
  // so a following call can transfer back to back. Any other wait lowers it first.
  task automatic send_item(bit func, logic [cgrt_pkg::IdW-1:0] id,
                           logic [cgrt_pkg::ChunkW-1:0] chunk, int unsigned sent);
    cgrt_pkg::in_t it;
    it.func          = func;
    it.packet_id     = id;
    it.request_chunk = chunk;
    it.packets_sent  = cgrt_pkg::CntW'(sent);
    hold_off(pick_gap());
    @(negedge clk);
    item  = it;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_replies(it);
    items_sent++;
  endtask

  task automatic send_payload(logic [cgrt_pkg::IdW-1:0] id);
    send_item(FuncPayload, id, cgrt_pkg::ChunkW'($urandom_range(0, 65535)),
              $urandom_range(0, 127));
  endtask

  task automatic send_check(logic [cgrt_pkg::ChunkW-1:0] chunk, int unsigned sent);
    send_item(FuncCheck, cgrt_pkg::IdW'($urandom_range(0, 65535)), chunk, sent);
  endtask

  // The sender stops until every reply owed so far has come back.
  task automatic wait_all_replies();
    @(negedge clk);
    start = 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // Invalid ids are ignored, while both ends of the bitmap get marked.
  // The full-size check then reports the 62 ids in between.
  task automatic test_payload_ids();
    send_payload(0);
    send_payload(65);
    send_payload(16'hFFFF);
    send_payload(16'h8000);
    send_payload(1);
    send_payload(cgrt_pkg::IdW'(MaxPackets));
    send_check(cur_chunk, MaxPackets);
    wait_all_replies();
  endtask

  // Counts above the bitmap size must walk exactly the full bitmap.
  task automatic test_large_count();
    send_check(cur_chunk, 127);
    send_check(cur_chunk, MaxPackets + 1);
    wait_all_replies();
  endtask

  // Completes one chunk so that an older chunk exists.
  // Then it sends stale checks (one with a count of zero, which must not finish the transfer)
  // and checks on future chunks, whose replies must carry the current chunk.
  task automatic test_stale_and_future();
    send_check(cur_chunk, 1);
    send_check(cur_chunk - 1'b1, 0);
    send_check(0, MaxPackets);
    send_check(16'hFFFF, 2);
    send_payload(1);
    send_payload(2);
    send_check(cur_chunk + 16'd5, 2);
    wait_all_replies();
  endtask

  // One well-formed chunk: deliver most ids, check, retransmit most gaps, check again.
  task automatic run_chunk_round();
    int unsigned span;
    int unsigned sent;
    int unsigned walk;
    bit          descend;
    logic [cgrt_pkg::ChunkW-1:0] req;
    span    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MaxPackets)
                                          : $urandom_range(1, 12);
    descend = $urandom_range(0, 1);
    for (int unsigned n = 1; n <= span; n++)
      if ($urandom_range(0, 4) != 0)
        send_payload(cgrt_pkg::IdW'(descend ? span + 1 - n : n));
    sent = ($urandom_range(0, 7) == 0) ? $urandom_range(span, 127) : span;
    walk = (sent > MaxPackets) ? MaxPackets : sent;
    req  = cur_chunk;
    if ($urandom_range(0, 9) == 0 && cur_chunk < 16'hFFF0)
      req = cgrt_pkg::ChunkW'(cur_chunk + $urandom_range(1, 3));
    send_check(req, sent);
    for (int unsigned n = 1; n <= walk; n++)
      if (!rx_map[n-1] && $urandom_range(0, 9) != 0) send_payload(cgrt_pkg::IdW'(n));
    send_check(cur_chunk, sent);
  endtask

  // Mostly well-formed chunks with random content. The rest is noise ids, stale checks,
  // future checks and occasional full drains.
  task automatic test_random_rounds();
    int unsigned goal;
    int unsigned pick;
    goal = items_sent + RandomItems;
    while (items_sent < goal) begin
      gaps_off = ($urandom_range(0, 4) == 0);
      pick     = $urandom_range(0, 99);
      if (pick < 70) begin
        run_chunk_round();
      end else if (pick < 80) begin
        send_payload(cgrt_pkg::IdW'($urandom_range(0, 65535)));
      end else if (pick < 88) begin
        if (cur_chunk != 0)
          send_check(cgrt_pkg::ChunkW'($urandom_range(0, cur_chunk - 1)),
                     $urandom_range(0, 127));
      end else if (pick < 95) begin
        if (cur_chunk != 16'hFFFF)
          send_check(cgrt_pkg::ChunkW'($urandom_range(cur_chunk + 1, 65535)),
                     $urandom_range(1, 127));
      end else begin
        wait_all_replies();
      end
    end
    gaps_off = 1'b0;
    wait_all_replies();
  endtask

  // Finishing is permanent until reset, so this runs last.
  // After the finish, payloads are dropped, checks answer finished, and stale checks stay stale.
  task automatic test_transfer_done();
    send_payload(3);
    send_check(cur_chunk, 0);
    send_payload(1);
    send_check(cur_chunk, 1);
    send_check(cur_chunk - 1'b1, 5);
    send_check(16'hFFFF, 0);
    wait_all_replies();
  endtask

  // Reply checker: every strobed reply is matched against the oldest expectation.
  always @(posedge clk) begin : check_replies
    cgrt_pkg::res_t got;
    cgrt_pkg::res_t want;
    if (rst_n === 1'b1 && reply_strobe === 1'b1) begin
      got = reply;
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with none expected", '0, got);
      end else begin
        want = expected_replies.pop_front();
        if (got.kind !== want.kind || got.reply_chunk !== want.reply_chunk ||
            got.missing_id !== want.missing_id || got.missing_total !== want.missing_total ||
            got.last !== want.last)
          report_mismatch("reply differs", want, got);
      end
    end
  end

  // Watchdog: the run ends if no transfer and no reply happens for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || reply_strobe === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    item           = '0;
    rx_map         = '0;
    cur_chunk      = 16'd1;
    xfer_done      = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    idle_cycles    = 0;
    gaps_off       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_payload_ids();
    test_large_count();
    test_stale_and_future();
    test_random_rounds();
    test_transfer_done();

    // Let any stray reply show up before the final verdict.
    wait_all_replies();
    repeat (TailCycles) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $display("%0d expected replies never arrived", expected_replies.size());
      mismatch_count += expected_replies.size();
    end
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
